@@ rtl/wsl_pkg.sv @@
package wsl_pkg;

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_CHUNK_ID,
		PH_SMPL_SIZE,
		PH_CHUNK_SIZE,
		PH_SKIP,
		PH_SMPL_BODY,
		PH_DONE
	} phase_t;

	localparam int unsigned CountW = 33;

	typedef logic [CountW-1:0] count_t;

	localparam logic [31:0] TagRiff = 32'h4646_4952;
	localparam logic [31:0] TagWave = 32'h4556_4157;
	localparam logic [31:0] TagSmpl = 32'h6C70_6D73;

	localparam int unsigned FileHeaderLen   = 12;
	localparam int unsigned CountOffset     = 28;
	localparam int unsigned LoopTableOffset = 36;
	localparam int unsigned LoopEntryLen    = 24;
	localparam int unsigned LoopStartOffset = 8;
	localparam int unsigned LoopEndOffset   = 12;

	localparam count_t TagLastIdx    = count_t'(3);
	localparam count_t HeaderLastIdx = count_t'(FileHeaderLen - 1);
	localparam count_t CountLastIdx  = count_t'(CountOffset + 3);
	localparam count_t StartLastIdx  = count_t'(LoopTableOffset + LoopStartOffset + 3);
	localparam count_t EndLastIdx    = count_t'(LoopTableOffset + LoopEndOffset + 3);
	localparam count_t BodyLastIdx   = count_t'(LoopTableOffset + LoopEntryLen - 1);

endpackage

@@ rtl/wsl_in_if.sv @@
interface wsl_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

@@ rtl/wsl_out_if.sv @@
interface wsl_out_if;
	logic        valid;
	logic        ready;
	logic        found;
	logic [31:0] loop_start;
	logic [31:0] loop_length;

	modport source (output valid, output found, output loop_start, output loop_length,
		input ready);
	modport sink (input valid, input found, input loop_start, input loop_length,
		output ready);
endinterface

@@ rtl/wav_sampler_loop_finder.sv @@
// Sampler loop finder for RIFF/WAVE files streamed one byte per item.
// The byte_in channel carries data_byte and last_byte, which marks the final byte of a
// file. The result channel carries found, loop_start and loop_length for the first loop
// of the first smpl chunk; on failure found is 0 and both values are 0.
// Each file gives exactly one result item. It is produced by the byte that decides it
// (a bad RIFF or WAVE tag, a zero loop count, an end not above the start, or data byte 59
// of the smpl chunk), or by the last byte when the file ends undecided.
// Latency: the result is valid in the cycle after the deciding byte is accepted.
// Throughput: one byte per cycle; the parse state is a counter and a four byte shift
// register updated by each byte, and the result sits in a single output register.
// A new byte is taken in the same cycle as a waiting result is taken, even when that
// byte decides the next result; while the receiver stalls with a result pending,
// byte_in.ready is low until the result is taken.
// After every last byte the parser returns to its reset state for the next file.
// Reset (arst_n low) clears the parser and drops any pending result.
module wav_sampler_loop_finder (
	input  logic     clk,
	input  logic     arst_n,
	wsl_in_if.sink   byte_in,
	wsl_out_if.source result
);

	wsl_pkg::phase_t phase_q, phase_d;
	wsl_pkg::count_t cnt_q, cnt_d;
	logic [31:0]     shift_q, shift_d;
	logic [31:0]     begin_q, begin_d;
	logic [31:0]     finish_q, finish_d;
	logic [32:0]     skip_len;

	logic        res_v;
	logic        res_found;
	logic [31:0] res_start;
	logic [31:0] res_length;

	logic        out_valid_q;
	logic        found_q;
	logic [31:0] start_q;
	logic [31:0] length_q;

	logic accept;

	assign byte_in.ready = !out_valid_q || result.ready;
	assign accept        = byte_in.valid && byte_in.ready;

	assign shift_d  = {byte_in.data_byte, shift_q[31:8]};
	assign skip_len = {1'b0, shift_d} + {32'd0, shift_d[0]};

	always_comb begin
		phase_d    = phase_q;
		cnt_d      = cnt_q;
		begin_d    = begin_q;
		finish_d   = finish_q;
		res_v      = 1'b0;
		res_found  = 1'b0;
		res_start  = '0;
		res_length = '0;
		case (phase_q)
			wsl_pkg::PH_HEADER: begin
				if (cnt_q == wsl_pkg::TagLastIdx && shift_d != wsl_pkg::TagRiff) begin
					res_v   = 1'b1;
					phase_d = wsl_pkg::PH_DONE;
				end else if (cnt_q == wsl_pkg::HeaderLastIdx) begin
					if (shift_d != wsl_pkg::TagWave) begin
						res_v   = 1'b1;
						phase_d = wsl_pkg::PH_DONE;
					end else begin
						phase_d = wsl_pkg::PH_CHUNK_ID;
						cnt_d   = '0;
					end
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			wsl_pkg::PH_CHUNK_ID: begin
				if (cnt_q == wsl_pkg::TagLastIdx) begin
					cnt_d   = '0;
					phase_d = (shift_d == wsl_pkg::TagSmpl) ? wsl_pkg::PH_SMPL_SIZE
						: wsl_pkg::PH_CHUNK_SIZE;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			wsl_pkg::PH_SMPL_SIZE: begin
				if (cnt_q == wsl_pkg::TagLastIdx) begin
					cnt_d   = '0;
					phase_d = wsl_pkg::PH_SMPL_BODY;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			wsl_pkg::PH_CHUNK_SIZE: begin
				if (cnt_q == wsl_pkg::TagLastIdx) begin
					cnt_d   = skip_len;
					phase_d = (skip_len == '0) ? wsl_pkg::PH_CHUNK_ID : wsl_pkg::PH_SKIP;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			wsl_pkg::PH_SKIP: begin
				if (cnt_q != '0) begin
					cnt_d = cnt_q - 1'b1;
				end
				if (cnt_d == '0) begin
					phase_d = wsl_pkg::PH_CHUNK_ID;
				end
			end
			wsl_pkg::PH_SMPL_BODY: begin
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == wsl_pkg::CountLastIdx) begin
					if (shift_d == '0) begin
						res_v   = 1'b1;
						phase_d = wsl_pkg::PH_DONE;
						cnt_d   = cnt_q;
					end
				end else if (cnt_q == wsl_pkg::StartLastIdx) begin
					begin_d = shift_d;
				end else if (cnt_q == wsl_pkg::EndLastIdx) begin
					finish_d = shift_d;
					if (shift_d <= begin_q) begin
						res_v   = 1'b1;
						phase_d = wsl_pkg::PH_DONE;
						cnt_d   = cnt_q;
					end
				end else if (cnt_q == wsl_pkg::BodyLastIdx) begin
					res_v      = 1'b1;
					res_found  = 1'b1;
					res_start  = begin_q;
					res_length = finish_q - begin_q;
					phase_d    = wsl_pkg::PH_DONE;
					cnt_d      = cnt_q;
				end
			end
			default: begin
			end
		endcase
		if (byte_in.last_byte) begin
			if (!res_v && phase_q != wsl_pkg::PH_DONE) begin
				res_v = 1'b1;
			end
			phase_d  = wsl_pkg::PH_HEADER;
			cnt_d    = '0;
			begin_d  = '0;
			finish_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= wsl_pkg::PH_HEADER;
			cnt_q    <= '0;
			shift_q  <= '0;
			begin_q  <= '0;
			finish_q <= '0;
		end else if (accept) begin
			phase_q  <= phase_d;
			cnt_q    <= cnt_d;
			shift_q  <= byte_in.last_byte ? 32'd0 : shift_d;
			begin_q  <= begin_d;
			finish_q <= finish_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && res_v) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && res_v) begin
			found_q  <= res_found;
			start_q  <= res_start;
			length_q <= res_length;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.found       = found_q;
	assign result.loop_start  = start_q;
	assign result.loop_length = length_q;

`ifndef ASSERT_OFF
	a_found_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.found |-> result.loop_length != '0)
		else $error("Found loop has zero length.");

	a_fail_zero_values: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.found |-> result.loop_start == '0
			&& result.loop_length == '0)
		else $error("Failure result carries nonzero values.");

	a_rearm_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		accept && byte_in.last_byte |=> phase_q == wsl_pkg::PH_HEADER && cnt_q == '0)
		else $error("Parser did not rearm after the last byte.");

	a_header_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == wsl_pkg::PH_HEADER |-> cnt_q < wsl_pkg::count_t'(wsl_pkg::FileHeaderLen))
		else $error("Header byte count out of range.");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !result.ready |-> !accept)
		else $error("Item accepted while a result is stalled.");
`endif

endmodule
